FILE: src/timeline_gap_fill_scheduler_defines.svh
// Assertion shorthands for the scheduler checker.
`ifndef TIMELINE_GAP_FILL_SCHEDULER_DEFINES_SVH
`define TIMELINE_GAP_FILL_SCHEDULER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, quiet during reset.
`define TGFS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tgfs check failed");

// Next-cycle implication.
`define TGFS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tgfs check failed");

`endif

FILE: src/tgfs_pkg.sv
package tgfs_pkg;

    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int TIME_BITS_DEF    = 32;

    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    localparam logic [1:0] ST_APPEND = 2'd0;
    localparam logic [1:0] ST_GAP    = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_CLEAR  = 2'd3;

endpackage

FILE: src/tgfs_seg_mem.sv
module tgfs_seg_mem #(
    parameter int DEPTH = tgfs_pkg::MAX_SEGMENTS_DEF,
    parameter int DW    = tgfs_pkg::TIME_BITS_DEF + 1
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DW-1:0]            i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DW-1:0]            o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: src/tgfs_sub.sv
// Shared subtractor: difference and borrow.
module tgfs_sub #(
    parameter int W = tgfs_pkg::TIME_BITS_DEF
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic [W-1:0] o_diff,
    output logic         o_borrow
);
    logic [W:0] w_full;

    assign w_full   = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff   = w_full[W-1:0];
    assign o_borrow = w_full[W];
endmodule

FILE: src/timeline_gap_fill_scheduler.sv
// Timeline gap-fill scheduler. The block holds one processor's timeline as an
// ordered list of idle and busy segments in a segment memory with one write
// and one read port, plus a running end time. Each request on the slave
// stream (tuser = request kind, tdata = earliest start and task length)
// yields exactly one result on the master stream (tuser = status, tdata =
// granted start, granted finish, timeline end and leading idle). A start at
// or past the end time is appended as an idle piece, when one is needed, and
// a busy piece. An earlier start walks the list backward, one segment per
// cycle through one shared subtractor; if a gap fits, the block then shifts
// the tail up one entry per cycle and writes up to three pieces, else it
// appends at the end time. A clear empties the list and goes straight to
// the result. s_axis_tready is high only while no request is in work; a
// finished result waits in the master output register and the next request
// is taken meanwhile, and a second finished result holds the block until
// that register drains. Rejected requests (store full) leave the timeline
// untouched.
module timeline_gap_fill_scheduler #(
    parameter int MAX_SEGMENTS = tgfs_pkg::MAX_SEGMENTS_DEF,
    parameter int TIME_BITS    = tgfs_pkg::TIME_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,   // earliest_start[31:0], task_length[47:32]
    input  logic         s_axis_tuser,   // req_type
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // granted_start, granted_finish,
                                         // timeline_end, first_busy_time
    output logic [1:0]   m_axis_tuser    // status
);
    localparam int TB = TIME_BITS;
    localparam int AW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int XW = ((TB > 16) ? TB : 16) + 1;
    localparam int SW = (TB > 32) ? TB : 32;
    localparam logic [TB-1:0] TMAX = {TB{1'b1}};

    typedef enum logic [3:0] {
        S_IDLE, S_PRIME, S_WALK, S_FIX, S_SH_RD, S_SH_WR, S_WR_LEAD,
        S_WR_TASK, S_WR_TRAIL, S_APPEND, S_AP_IDLE, S_AP_TASK, S_DONE
    } t_state;

    t_state        r_state;
    logic [TB-1:0] r_start, r_end, r_first, r_cur, r_gs, r_gd, r_tgt;
    logic [TB-1:0] r_lead, r_trail, r_when, r_idle, r_tdur;
    logic [15:0]   r_len;
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_k, r_gi, r_src, r_wpos;
    logic          r_found;
    logic [1:0]    r_needed;
    logic [31:0]   r_res_start, r_res_fin;
    logic [1:0]    r_res_st;
    logic          r_mv;
    logic [127:0]  r_mdata;
    logic [1:0]    r_muser;

    // segment memory ports; busy flag in the top bit
    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [TB:0]   w_wdata, w_rdata;

    tgfs_seg_mem #(.DEPTH(MAX_SEGMENTS), .DW(TB + 1)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // shared subtractor, operands picked by state
    logic [TB-1:0] w_sa, w_sb, w_diff;
    logic          w_borrow;

    tgfs_sub #(.W(TB)) u_sub (
        .i_a      (w_sa),
        .i_b      (w_sb),
        .o_diff   (w_diff),
        .o_borrow (w_borrow)
    );

    always_comb begin
        case (r_state)
            S_FIX: begin
                w_sa = r_tgt;
                w_sb = r_gs;
            end
            S_APPEND: begin
                w_sa = r_when;
                w_sb = r_end;
            end
            default: begin
                w_sa = r_cur;
                w_sb = w_rdata[TB-1:0];
            end
        endcase
    end

    // input start, saturated to the time range
    logic [SW-1:0] w_in_start;
    logic [TB-1:0] w_start_sat;
    assign w_in_start  = SW'(s_axis_tdata[31:0]);
    assign w_start_sat = (w_in_start > SW'(TMAX)) ? TMAX : w_in_start[TB-1:0];

    logic [XW-1:0] w_len_x, w_sl, w_gend, w_tl, w_finx;
    logic [TB-1:0] w_len_tb, w_d, w_cur_n, w_trail, w_fin;
    logic          w_busy, w_sat;
    logic [1:0]    w_fix_need, w_ap_need;
    logic [CW:0]   w_fix_tot, w_ap_tot;

    assign w_len_x    = XW'(r_len);
    assign w_len_tb   = w_len_x[TB-1:0];
    assign w_sl       = XW'(r_start) + w_len_x;
    assign w_d        = w_rdata[TB-1:0];
    assign w_busy     = w_rdata[TB];
    assign w_cur_n    = w_borrow ? '0 : w_diff;
    assign w_gend     = XW'(r_gs) + XW'(r_gd);
    assign w_tl       = XW'(r_tgt) + w_len_x;
    assign w_trail    = (w_gend >= w_tl) ? TB'(w_gend - w_tl) : '0;
    assign w_fix_need = {1'b0, (w_diff != '0)} + {1'b0, (w_trail != '0)};
    assign w_fix_tot  = (CW + 1)'(r_count) + (CW + 1)'(w_fix_need);
    assign w_finx     = XW'(r_when) + w_len_x;
    assign w_sat      = w_finx > XW'(TMAX);
    assign w_fin      = w_sat ? TMAX : w_finx[TB-1:0];
    assign w_ap_need  = {1'b0, (w_diff != '0)} + 2'd1;
    assign w_ap_tot   = (CW + 1)'(r_count) + (CW + 1)'(w_ap_need);

    // memory access per state
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_wpos;
        w_wdata = {1'b0, r_lead};
        w_raddr = r_k;
        case (r_state)
            S_PRIME:   w_raddr = AW'(r_count - CW'(1));
            S_WALK:    w_raddr = r_k - AW'(1);
            S_SH_RD:   w_raddr = r_src;
            S_SH_WR: begin
                w_we    = 1'b1;
                w_waddr = r_src + AW'(r_needed);
                w_wdata = w_rdata;
                w_raddr = r_src - AW'(1);
            end
            S_WR_LEAD: w_we = 1'b1;
            S_WR_TASK: begin
                w_we    = 1'b1;
                w_wdata = {1'b1, w_len_tb};
            end
            S_WR_TRAIL: begin
                w_we    = 1'b1;
                w_wdata = {1'b0, r_trail};
            end
            S_AP_IDLE: begin
                w_we    = 1'b1;
                w_waddr = AW'(r_count);
                w_wdata = {1'b0, r_idle};
            end
            S_AP_TASK: begin
                w_we    = 1'b1;
                w_waddr = AW'(r_count);
                w_wdata = {1'b1, r_tdur};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_end   <= '0;
            r_first <= '0;
            r_mv    <= 1'b0;
        end else begin
            // drop the output transaction once taken; S_DONE reloads it itself
            if (r_mv && m_axis_tready && r_state != S_DONE) begin
                r_mv <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_start <= w_start_sat;
                        r_len   <= s_axis_tdata[47:32];
                        r_cur   <= r_end;
                        r_found <= 1'b0;
                        if (s_axis_tuser == tgfs_pkg::REQ_CLEAR) begin
                            // empty the list; stale entries are never read
                            r_count     <= '0;
                            r_end       <= '0;
                            r_first     <= '0;
                            r_res_start <= '0;
                            r_res_fin   <= '0;
                            r_res_st    <= tgfs_pkg::ST_CLEAR;
                            r_state     <= S_DONE;
                        end else if (w_start_sat >= r_end) begin
                            r_when  <= w_start_sat;
                            r_state <= S_APPEND;
                        end else begin
                            r_k     <= AW'(r_count - CW'(1));
                            r_state <= S_PRIME;
                        end
                    end
                end
                S_PRIME: r_state <= S_WALK;
                S_WALK: begin
                    // one segment per cycle, newest first
                    logic stop;
                    stop = 1'b0;
                    r_cur <= w_cur_n;
                    if (w_busy) begin
                        if (XW'(w_cur_n) < w_sl) begin
                            stop = 1'b1;
                        end
                    end else if (XW'(w_d) >= w_len_x) begin
                        r_gi    <= r_k;
                        r_gs    <= w_cur_n;
                        r_gd    <= w_d;
                        r_found <= 1'b1;
                        if (w_cur_n < r_start) begin
                            r_tgt <= r_start;
                            stop = 1'b1;
                        end else begin
                            r_tgt <= w_cur_n;
                        end
                    end
                    if (stop || r_k == '0) begin
                        // found flag updated this cycle counts too
                        if (r_found || (!w_busy && XW'(w_d) >= w_len_x)) begin
                            r_state <= S_FIX;
                        end else begin
                            r_when  <= r_end;
                            r_state <= S_APPEND;
                        end
                    end else begin
                        r_k <= r_k - AW'(1);
                    end
                end
                S_FIX: begin
                    r_lead   <= w_diff;
                    r_trail  <= w_trail;
                    r_needed <= w_fix_need;
                    r_wpos   <= r_gi;
                    r_src    <= AW'(r_count - CW'(1));
                    if (w_fix_tot > (CW + 1)'(MAX_SEGMENTS)) begin
                        r_res_start <= '0;
                        r_res_fin   <= '0;
                        r_res_st    <= tgfs_pkg::ST_FULL;
                        r_state     <= S_DONE;
                    end else if (w_fix_need != 2'd0 &&
                                 (CW + 1)'(r_count) > (CW + 1)'(r_gi) + (CW + 1)'(1)) begin
                        r_state <= S_SH_RD;
                    end else if (w_diff != '0) begin
                        r_state <= S_WR_LEAD;
                    end else begin
                        r_state <= S_WR_TASK;
                    end
                end
                S_SH_RD: r_state <= S_SH_WR;
                S_SH_WR: begin
                    // move the tail up by the number of extra pieces
                    if (r_src == r_gi + AW'(1)) begin
                        r_state <= (r_lead != '0) ? S_WR_LEAD : S_WR_TASK;
                    end else begin
                        r_src <= r_src - AW'(1);
                    end
                end
                S_WR_LEAD: begin
                    r_wpos  <= r_wpos + AW'(1);
                    r_state <= S_WR_TASK;
                end
                S_WR_TASK: begin
                    r_wpos <= r_wpos + AW'(1);
                    if (r_trail != '0) begin
                        r_state <= S_WR_TRAIL;
                    end else begin
                        r_count     <= r_count + CW'(r_needed);
                        r_res_start <= 32'(r_tgt);
                        r_res_fin   <= 32'(w_tl);
                        r_res_st    <= tgfs_pkg::ST_GAP;
                        r_state     <= S_DONE;
                    end
                    if (r_gi == '0) begin
                        // the gap was the leading idle segment
                        r_first <= r_lead;
                    end
                end
                S_WR_TRAIL: begin
                    r_count     <= r_count + CW'(r_needed);
                    r_res_start <= 32'(r_tgt);
                    r_res_fin   <= 32'(w_tl);
                    r_res_st    <= tgfs_pkg::ST_GAP;
                    r_state     <= S_DONE;
                end
                S_APPEND: begin
                    r_idle <= w_diff;
                    r_tdur <= w_fin - r_when;
                    if (w_ap_tot > (CW + 1)'(MAX_SEGMENTS)) begin
                        r_res_start <= '0;
                        r_res_fin   <= '0;
                        r_res_st    <= tgfs_pkg::ST_FULL;
                        r_state     <= S_DONE;
                    end else begin
                        r_res_start <= 32'(r_when);
                        r_res_fin   <= 32'(w_fin);
                        r_res_st    <= tgfs_pkg::ST_APPEND;
                        if (r_count == '0) begin
                            r_first <= w_diff;
                        end
                        r_end   <= w_fin;
                        r_state <= (w_diff != '0) ? S_AP_IDLE : S_AP_TASK;
                    end
                end
                S_AP_IDLE: begin
                    r_count <= r_count + CW'(1);
                    r_state <= S_AP_TASK;
                end
                S_AP_TASK: begin
                    r_count <= r_count + CW'(1);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (!r_mv || m_axis_tready) begin
                        r_mv    <= 1'b1;
                        r_mdata <= {32'(r_first), 32'(r_end), r_res_fin, r_res_start};
                        r_muser <= r_res_st;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_mv;
    assign m_axis_tdata  = r_mdata;
    assign m_axis_tuser  = r_muser;
endmodule

FILE: src/tgfs_checker.sv
`include "timeline_gap_fill_scheduler_defines.svh"

module tgfs_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);
    logic w_in_go;
    assign w_in_go = s_axis_tvalid && s_axis_tready;

    `TGFS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `TGFS_ASSERT_NEXT(a_busy_after_take, w_in_go, !s_axis_tready)
    `TGFS_ASSERT_NOW(a_full_zero, m_axis_tvalid && m_axis_tuser == tgfs_pkg::ST_FULL, m_axis_tdata[63:0] == 64'd0)
    `TGFS_ASSERT_NOW(a_clear_zero, m_axis_tvalid && m_axis_tuser == tgfs_pkg::ST_CLEAR, m_axis_tdata == 128'd0)
endmodule

bind timeline_gap_fill_scheduler tgfs_checker u_tgfs_checker (.*);
